// File: rtl/pes_pkg.sv
// Shared constants and controller/datapath interface types for the
// product-except-self block. No dependencies.
package pes_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_LEN_DEF = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // input transaction accepted
        logic walk_start;  // last element seen: point index at final stored entry
        logic rd;          // read both stores at the current index
        logic walk_upd;    // apply suffix product, step index down
        logic idx_inc;     // result taken, step index up
        logic clear;       // vector done: return accumulators to reset values
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic idx_zero;
        logic idx_last;
        logic dropped;
    } t_sts;

endpackage

// File: rtl/pes_ctrl.sv
// Controller for the product-except-self block: sequences load, backward
// walk and emission. Depends on pes_pkg.
module pes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last_element,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output pes_pkg::t_cmd o_cmd,
    input  pes_pkg::t_sts i_sts
);

    localparam logic [2:0] S_LOAD     = 3'd0;
    localparam logic [2:0] S_WALK_RD  = 3'd1;
    localparam logic [2:0] S_WALK_WR  = 3'd2;
    localparam logic [2:0] S_EMIT_RD  = 3'd3;
    localparam logic [2:0] S_EMIT_OUT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_element) begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WALK_WR;
            end
            S_WALK_WR: begin
                o_cmd.walk_upd = 1'b1;
                n_state        = i_sts.idx_zero ? S_EMIT_RD : S_WALK_RD;
            end
            S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (i_sts.idx_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/pes_datapath.sv
// Datapath for the product-except-self block: prefix and element stores,
// running prefix/suffix products and the position index. Depends on pes_pkg.
module pes_datapath #(
    parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pes_pkg::t_cmd              i_cmd,
    output pes_pkg::t_sts              o_sts,
    input  logic [pes_pkg::DATA_W-1:0] i_value,
    output logic [pes_pkg::DATA_W-1:0] o_product
);

    localparam int DW = pes_pkg::DATA_W;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [DW-1:0] partial_mem [MAX_LEN];
    logic [DW-1:0] elem_mem    [MAX_LEN];

    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] r_prefix, n_prefix;
    logic [DW-1:0] r_suffix, n_suffix;
    logic          r_dropped, n_dropped;
    logic [AW-1:0] r_idx, n_idx;
    logic [DW-1:0] r_part_rd;
    logic [DW-1:0] r_elem_rd;

    logic          full;
    logic          store;
    logic [CW-1:0] start_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    assign full  = (r_count == CW'(MAX_LEN));
    assign store = i_cmd.load && !full;

    // Final stored position once this last element is in
    assign start_idx = full ? (r_count - CW'(1)) : r_count;

    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_sts.dropped  = r_dropped;
    assign o_product      = r_part_rd;

    always_comb begin
        n_count   = r_count;
        n_prefix  = r_prefix;
        n_suffix  = r_suffix;
        n_dropped = r_dropped;
        n_idx     = r_idx;
        if (i_cmd.clear) begin
            n_count   = '0;
            n_prefix  = DW'(1);
            n_suffix  = DW'(1);
            n_dropped = 1'b0;
            n_idx     = '0;
        end else begin
            if (store) begin
                n_count  = r_count + CW'(1);
                n_prefix = r_prefix * i_value;
            end else if (i_cmd.load) begin
                n_dropped = 1'b1;
            end
            if (i_cmd.walk_start) begin
                n_idx = start_idx[AW-1:0];
            end else if (i_cmd.walk_upd) begin
                n_suffix = r_suffix * r_elem_rd;
                if (!o_sts.idx_zero) begin
                    n_idx = r_idx - AW'(1);
                end
            end else if (i_cmd.idx_inc) begin
                n_idx = r_idx + AW'(1);
            end
        end
    end

    // One write port on the prefix store: load writes the prefix, walk the result
    always_comb begin
        wr_en   = store || i_cmd.walk_upd;
        wr_addr = store ? r_count[AW-1:0] : r_idx;
        wr_data = store ? r_prefix : (r_part_rd * r_suffix);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            partial_mem[wr_addr] <= wr_data;
        end
        if (store) begin
            elem_mem[r_count[AW-1:0]] <= i_value;
        end
        if (i_cmd.rd) begin
            r_part_rd <= partial_mem[r_idx];
            r_elem_rd <= elem_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_prefix  <= DW'(1);
            r_suffix  <= DW'(1);
            r_dropped <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_count   <= n_count;
            r_prefix  <= n_prefix;
            r_suffix  <= n_suffix;
            r_dropped <= n_dropped;
            r_idx     <= n_idx;
        end
    end

endmodule

// File: rtl/product_except_self_top.sv
// Product of all other elements for each position of a vector.
//
// Input channel (i_valid/o_ready): one signed 32-bit element per transaction,
// i_last_element high on the final one. Output channel (o_valid/i_ready): one
// result per stored position in index order, o_last_result on the final one,
// o_overflowed high on every result of a vector that had elements dropped.
// Up to MAX_LEN elements are stored; further elements are dropped, and a
// dropped last element still closes the vector. Products wrap to 32 bits.
// Loading does one prefix multiply per element. After the last element the
// stores are walked backwards, each element with a registered read, then a
// suffix multiply and write back; then results are read out, each with a
// registered read through the single read port of the stores, then output.
// o_ready is low from the last element until the final result is taken. A
// stalled receiver holds the current result and the block.
// Reset (synchronous, active low) empties the vector and returns to loading.
// Depends on pes_pkg, pes_ctrl and pes_datapath.
module product_except_self_top #(
    parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [pes_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last_element,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [pes_pkg::DATA_W-1:0] o_product,
    output logic                              o_last_result,
    output logic                              o_overflowed
);

    pes_pkg::t_cmd               cmd;
    pes_pkg::t_sts               sts;
    logic [pes_pkg::DATA_W-1:0]  product;

    pes_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_last_element (i_last_element),
        .o_ready        (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    pes_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_value   ($unsigned(i_value)),
        .o_product (product)
    );

    assign o_product     = $signed(product);
    assign o_last_result = sts.idx_last;
    assign o_overflowed  = sts.dropped;

endmodule

// File: tb/tb_product_except_self_top.sv
// Self-checking bench for product_except_self_top: random and directed vectors, with
// short, full and overflowing lengths, under random gaps on both channels.
// Depends on pes_pkg and the product_except_self_top RTL.
module tb_product_except_self_top;

    localparam int STORE_DEPTH = pes_pkg::MAX_LEN_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int QUIET_TAIL  = 40;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic signed [pes_pkg::DATA_W-1:0] value;
        logic                              last_element;
    } t_element;

    typedef struct packed {
        logic signed [pes_pkg::DATA_W-1:0] product;
        logic                              last_result;
        logic                              overflowed;
    } t_product_result;

    logic                              i_clk;
    logic                              i_rst_n        = 1'b0;
    logic                              i_valid        = 1'b0;
    logic signed [pes_pkg::DATA_W-1:0] i_value        = '0;
    logic                              i_last_element = 1'b0;
    logic                              i_ready        = 1'b0;
    logic                              o_ready;
    logic                              o_valid;
    logic signed [pes_pkg::DATA_W-1:0] o_product;
    logic                              o_last_result;
    logic                              o_overflowed;

    t_element        element_q[$];
    t_product_result expected_products[$];
    int              total_elements = 0;
    int              elements_taken = 0;
    int              err_cnt        = 0;
    int              cycle_cnt      = 0;
    int              send_gap       = 0;
    int              send_idle_pct  = 12;
    int              recv_stall     = 0;
    int              recv_idle_pct  = 12;

    // Predictor state for the vector being loaded
    logic [31:0] prefix_mem [STORE_DEPTH];
    logic [31:0] elem_mem   [STORE_DEPTH];
    int          stored_cnt  = 0;
    logic [31:0] prefix_run  = 32'd1;
    logic        drop_seen   = 1'b0;

    product_except_self_top #(
        .MAX_LEN (STORE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_product      (o_product),
        .o_last_result  (o_last_result),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Store prefix and element, or drop; on the last element walk back and queue results
    task automatic absorb_element(input logic [31:0] v, input logic last_el);
        logic [31:0]     suffix_run;
        t_product_result res;
        if (stored_cnt < STORE_DEPTH) begin
            prefix_mem[stored_cnt] = prefix_run;
            elem_mem[stored_cnt]   = v;
            prefix_run             = prefix_run * v;
            stored_cnt++;
        end else begin
            drop_seen = 1'b1;
        end
        if (last_el) begin
            suffix_run = 32'd1;
            for (int i = stored_cnt - 1; i >= 0; i--) begin
                prefix_mem[i] = prefix_mem[i] * suffix_run;
                suffix_run    = suffix_run * elem_mem[i];
            end
            for (int i = 0; i < stored_cnt; i++) begin
                res.product     = prefix_mem[i];
                res.last_result = (i == stored_cnt - 1);
                res.overflowed  = drop_seen;
                expected_products.push_back(res);
            end
            stored_cnt = 0;
            prefix_run = 32'd1;
            drop_seen  = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0000_0001;
                    default: v = 32'hffff_ffff;
                endcase
            end
            1, 2: v = $urandom_range(0, 6) - 3;
            3, 4, 5: v = $urandom | 32'd1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_element(input logic [31:0] v, input logic last_el);
        t_element e;
        e.value        = v;
        e.last_element = last_el;
        element_q.push_back(e);
        total_elements++;
    endtask

    task automatic add_random_vector(input int len);
        for (int i = 0; i < len; i++)
            add_element(pick_value(), i == len - 1);
    endtask

    // Driver: predict on each accepted transaction, hold valid until taken
    always @(posedge i_clk) begin : driver
        t_element nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_element(i_value, i_last_element);
                elements_taken++;
            end
            if (!(i_valid && !o_ready)) begin
                if ($urandom_range(0, 199) == 0)
                    send_idle_pct = $urandom_range(0, 2) * 12;
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (element_q.size() > 0) begin
                    nxt = element_q.pop_front();
                    i_valid        <= 1'b1;
                    i_value        <= nxt.value;
                    i_last_element <= nxt.last_element;
                    if (element_q.size() > QUIET_TAIL
                            && $urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 17);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction, stall the receiver in bursts
    always @(posedge i_clk) begin : monitor
        t_product_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_products.size() == 0) begin
                    report_mismatch("result with none pending", o_product, '0);
                end else begin
                    want = expected_products.pop_front();
                    if (o_product !== want.product)
                        report_mismatch("product", o_product, want.product);
                    if (o_last_result !== want.last_result)
                        report_mismatch("last_result", 32'(o_last_result),
                                        32'(want.last_result));
                    if (o_overflowed !== want.overflowed)
                        report_mismatch("overflowed", 32'(o_overflowed),
                                        32'(want.overflowed));
                end
            end
            if ($urandom_range(0, 199) == 0)
                recv_idle_pct = $urandom_range(0, 2) * 12;
            if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (element_q.size() > QUIET_TAIL && $urandom_range(0, 99) < recv_idle_pct)
                    recv_stall = $urandom_range(1, 17);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_product_except_self_top: errors");
            $finish;
        end
    end

    initial begin
        // Single elements give the empty product
        add_element(32'd5, 1'b1);
        add_element(32'h8000_0000, 1'b1);
        // Extremes against each other
        add_element(32'h7fff_ffff, 1'b0);
        add_element(32'h8000_0000, 1'b1);
        // One zero, then two zeros
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'd0, 1'b0);
        add_element(32'd3, 1'b1);
        add_element(32'd0, 1'b0);
        add_element(32'd0, 1'b1);
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'hffff_ffff, 1'b1);
        add_element(32'h7fff_ffff, 1'b0);
        add_element(32'h7fff_ffff, 1'b0);
        add_element(32'hffff_fffe, 1'b1);

        // Full store, dropped last element, several dropped trailing elements
        add_random_vector(STORE_DEPTH);
        add_random_vector(STORE_DEPTH + 1);
        add_random_vector(STORE_DEPTH + 6);
        while (total_elements < 420) begin
            if ($urandom_range(0, 7) == 0)
                add_random_vector($urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 8));
            else
                add_random_vector($urandom_range(1, 10));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (elements_taken != total_elements || expected_products.size() != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0)
            $display("tb_product_except_self_top: clean");
        else
            $display("tb_product_except_self_top: errors");
        $finish;
    end

endmodule
